>>> sv/afcg_pkg.sv
// Shared widths, mode codes and register indexes for the adaptive far clip governor.
// No dependencies; compile first.
`default_nettype none

package afcg_pkg;

  // Field widths fixed by the item and register formats
  localparam int unsigned ELAPSED_W  = 16;
  localparam int unsigned FPS_W      = 20;
  localparam int unsigned DIST_W     = 24;
  localparam int unsigned TOTAL_W    = 17;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [FPS_W-1:0] FPS_MAX = '1;

  // Clip modes
  localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIXED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ADAPT = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_DIST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FPS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FPS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_DIST  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST   = 3'd6;

endpackage

`default_nettype wire

>>> sv/afcg_if.sv
// Valid/ready channel interfaces: frame input, distance result, register write.
// Depends on afcg_pkg for field widths.
`default_nettype none

interface afcg_in_if;
  logic                            valid;
  logic                            ready;
  logic [afcg_pkg::ELAPSED_W-1:0]  elapsed_ms;

  modport source (output valid, output elapsed_ms, input ready);
  modport sink   (input valid, input elapsed_ms, output ready);
endinterface

interface afcg_out_if;
  logic                         valid;
  logic                         ready;
  logic                         plane_enabled;
  logic [afcg_pkg::DIST_W-1:0]  clip_distance;
  logic                         distance_changed;

  modport source (output valid, output plane_enabled, output clip_distance,
                  output distance_changed, input ready);
  modport sink   (input valid, input plane_enabled, input clip_distance,
                  input distance_changed, output ready);
endinterface

interface afcg_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [afcg_pkg::CFG_IDX_W-1:0]   index;
  logic [afcg_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> sv/afcg_div.sv
// Restoring divider, one quotient bit per cycle, for the frame rate estimate.
// Depends on afcg_pkg for the divisor width.
`default_nettype none

module afcg_div #(
  parameter int unsigned DIVIDEND_W = 18
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [DIVIDEND_W-1:0]           dividend_i,
  input  logic [afcg_pkg::ELAPSED_W-1:0]  divisor_i,
  output logic                            done_o,
  output logic [DIVIDEND_W-1:0]           quot_o
);

  localparam int unsigned DV_W  = afcg_pkg::ELAPSED_W;
  localparam int unsigned CNT_W = $clog2(DIVIDEND_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DV_W-1:0]   rem_q, rem_d;
  logic [DV_W-1:0]   dvs_q, dvs_d;
  logic [DIVIDEND_W-1:0] quot_q, quot_d;

  logic [DV_W:0] trial;
  logic [DV_W:0] trial_sub;

  // Shift the next dividend bit into the partial remainder and try a subtract
  assign trial     = {rem_q, quot_q[DIVIDEND_W-1]};
  assign trial_sub = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIVIDEND_W - 1);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quot_d = dividend_i;
    end else if (busy_q) begin
      if (!trial_sub[DV_W]) begin
        rem_d  = trial_sub[DV_W-1:0];
        quot_d = {quot_q[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_d  = trial[DV_W-1:0];
        quot_d = {quot_q[DIVIDEND_W-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

>>> sv/adaptive_far_clip_governor_top.sv
// Adaptive far clip governor: top level with the control sequencer and state.
// Depends on afcg_pkg, the channel interfaces in afcg_if and the divider afcg_div.
//
// Usage:
//   in_i   carries one item per rendered frame: elapsed_ms since the last frame.
//   out_o  returns exactly one item per input item: plane_enabled,
//          clip_distance (unsigned, FRAC_BITS fraction bits) and
//          distance_changed.
//   cfg_i  writes one register per handshake (index, data); it is always ready.
//          Write only while the block is idle. Writing clip_mode clears the
//          rate estimate, accumulated time and adaptive distance.
// Sequencing:
//   Off and fixed modes, and the first adaptive frame, go from idle straight to
//   the done step. A later adaptive frame runs a restoring divider that retires
//   one quotient bit per cycle over 10 + FRAC_BITS bits, then smooth, compare and
//   adjust steps; compare and adjust are skipped when the adjust period does not
//   end. Zero time skips the divider.
//   in_i.ready is high only while the sequencer waits for a new item.
// Reset: control, state and configuration registers reset; working and output data
//   registers do not. Smoothed rate starts at 30 fps, no distance set, mode off.
// Stall: a finished result waits in the output register; the next item may be
//   accepted and worked on meanwhile, and its result waits until the output
//   register frees up.
`default_nettype none

module adaptive_far_clip_governor_top #(
  parameter int unsigned FRAC_BITS        = 8,
  parameter int unsigned ADJUST_PERIOD_MS = 500
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  afcg_in_if.sink    in_i,
  afcg_out_if.source out_o,
  afcg_cfg_if.sink   cfg_i
);

  localparam int unsigned FPS_W   = afcg_pkg::FPS_W;
  localparam int unsigned DIST_W  = afcg_pkg::DIST_W;
  localparam int unsigned TOTAL_W = afcg_pkg::TOTAL_W;
  localparam int unsigned EL_W    = afcg_pkg::ELAPSED_W;
  localparam int unsigned MODE_W  = afcg_pkg::MODE_W;

  // 1000 ms in the fixed point rate format; 1000 needs 10 integer bits
  localparam int unsigned DIV_W = 10 + FRAC_BITS;
  localparam int unsigned SAT_W = (DIV_W > FPS_W) ? DIV_W : FPS_W;
  localparam int unsigned SUM_W = DIST_W + 1;

  localparam logic [DIV_W-1:0]   ONE_SEC       = DIV_W'(1000 << FRAC_BITS);
  localparam logic [FPS_W-1:0]   FPS_START     = FPS_W'(30 << FRAC_BITS);
  localparam logic [FPS_W-1:0]   MIN_FPS_RST   = FPS_W'(20 << FRAC_BITS);
  localparam logic [FPS_W-1:0]   MAX_FPS_RST   = FPS_W'(40 << FRAC_BITS);
  localparam logic [DIST_W-1:0]  MIN_DIST_RST  = DIST_W'(1 << FRAC_BITS);
  localparam logic [DIST_W-1:0]  INIT_DIST_RST = DIST_W'(200 << FRAC_BITS);
  localparam logic [DIST_W-1:0]  MAX_DIST_RST  = DIST_W'(1000 << FRAC_BITS);
  localparam logic [TOTAL_W-1:0] PERIOD        = TOTAL_W'(ADJUST_PERIOD_MS);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIV    = 3'd1;
  localparam logic [2:0] S_SMOOTH = 3'd2;
  localparam logic [2:0] S_ADJ1   = 3'd3;
  localparam logic [2:0] S_ADJ2   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  // Configuration registers
  logic [MODE_W-1:0] mode_q;
  logic [DIST_W-1:0] fixed_dist_q;
  logic [FPS_W-1:0]  min_fps_q;
  logic [FPS_W-1:0]  max_fps_q;
  logic [DIST_W-1:0] min_dist_q;
  logic [DIST_W-1:0] init_dist_q;
  logic [DIST_W-1:0] max_dist_q;

  // Governor state
  logic [2:0]         state_q, state_d;
  logic               rate_valid_q, rate_valid_d;
  logic [FPS_W-1:0]   smoothed_q, smoothed_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [DIST_W-1:0]  dist_q, dist_d;
  logic               dist_set_q, dist_set_d;

  // Per-item working registers
  logic [EL_W-1:0]    elapsed_q, elapsed_d;
  logic [FPS_W-1:0]   fps_q, fps_d;
  logic [DIST_W-1:0]  cur_q, cur_d;
  logic [FPS_W-1:0]   diff_q, diff_d;
  logic               below_q, below_d;
  logic               changed_q, changed_d;

  // Output register
  logic               out_valid_q, out_valid_d;
  logic               out_en_q, out_en_d;
  logic [DIST_W-1:0]  out_dist_q, out_dist_d;
  logic               out_chg_q, out_chg_d;

  logic in_fire, cfg_fire, mode_wr;
  logic div_start, div_done;
  logic [DIV_W-1:0]   div_quot;
  logic [DIV_W-1:0]   sat_in;
  logic [SAT_W-1:0]   sat_ext;
  logic [FPS_W-1:0]   fps_sat;
  logic [FPS_W:0]     smooth_sum;
  logic [TOTAL_W-1:0] total_sum;
  logic [SUM_W-1:0]   low_sum;
  logic [SUM_W-1:0]   high_sum;
  logic [DIST_W-1:0]  cur_sub;

  assign in_fire  = in_i.valid && in_i.ready;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;
  assign mode_wr  = cfg_fire && (cfg_i.index == afcg_pkg::REG_CLIP_MODE);

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // Frame rate: divider quotient, or the one-second constant for zero elapsed
  // time; clamp to the rate field
  assign sat_in  = (state_q == S_DIV) ? div_quot : ONE_SEC;
  assign sat_ext = SAT_W'(sat_in);
  assign fps_sat = (sat_ext > SAT_W'(afcg_pkg::FPS_MAX)) ? afcg_pkg::FPS_MAX
                                                         : sat_ext[FPS_W-1:0];

  assign smooth_sum = {1'b0, fps_q} + {1'b0, smoothed_q};
  assign total_sum  = total_q + TOTAL_W'(elapsed_q);
  assign low_sum    = SUM_W'(diff_q) + {1'b0, min_dist_q};
  assign high_sum   = {1'b0, cur_q} + SUM_W'(diff_q);
  assign cur_sub    = cur_q - DIST_W'(diff_q);

  afcg_div #(
    .DIVIDEND_W (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ONE_SEC),
    .divisor_i  (in_i.elapsed_ms),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d      = state_q;
    rate_valid_d = rate_valid_q;
    smoothed_d   = smoothed_q;
    total_d      = total_q;
    dist_d       = dist_q;
    dist_set_d   = dist_set_q;
    elapsed_d    = elapsed_q;
    fps_d        = fps_q;
    cur_d        = cur_q;
    diff_d       = diff_q;
    below_d      = below_q;
    changed_d    = changed_q;
    out_valid_d  = out_valid_q;
    out_en_d     = out_en_q;
    out_dist_d   = out_dist_q;
    out_chg_d    = out_chg_q;
    div_start    = 1'b0;

    // Drop the result once the receiver takes it
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          elapsed_d = in_i.elapsed_ms;
          changed_d = 1'b0;
          if (mode_q == afcg_pkg::MODE_ADAPT) begin
            if (!rate_valid_q) begin
              // First adaptive frame only arms the rate estimate
              rate_valid_d = 1'b1;
              state_d      = S_DONE;
            end else if (in_i.elapsed_ms == '0) begin
              fps_d   = fps_sat;
              state_d = S_SMOOTH;
            end else begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          fps_d   = fps_sat;
          state_d = S_SMOOTH;
        end
      end
      S_SMOOTH: begin
        smoothed_d = smooth_sum[FPS_W:1];
        if (total_sum > PERIOD) begin
          total_d = '0;
          state_d = S_ADJ1;
        end else begin
          total_d = total_sum;
          state_d = S_DONE;
        end
      end
      S_ADJ1: begin
        cur_d = dist_set_q ? dist_q : init_dist_q;
        if (smoothed_q < min_fps_q) begin
          below_d = 1'b1;
          diff_d  = min_fps_q - smoothed_q;
          state_d = S_ADJ2;
        end else if (smoothed_q > max_fps_q) begin
          below_d = 1'b0;
          diff_d  = smoothed_q - max_fps_q;
          state_d = S_ADJ2;
        end else begin
          state_d = S_DONE;
        end
      end
      S_ADJ2: begin
        // Lower by the shortfall with a floor, or raise by the excess with a cap
        if (below_q) begin
          dist_d = ({1'b0, cur_q} < low_sum) ? min_dist_q : cur_sub;
        end else begin
          dist_d = (high_sum > {1'b0, max_dist_q}) ? max_dist_q
                                                   : high_sum[DIST_W-1:0];
        end
        dist_set_d = 1'b1;
        changed_d  = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        // Hold here until the output register is free
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_chg_d   = 1'b0;
          case (mode_q)
            afcg_pkg::MODE_FIXED: begin
              out_en_d   = 1'b1;
              out_dist_d = fixed_dist_q;
            end
            afcg_pkg::MODE_ADAPT: begin
              out_en_d   = 1'b1;
              out_dist_d = dist_set_q ? dist_q : '0;
              out_chg_d  = changed_q;
            end
            default: begin
              out_en_d   = 1'b0;
              out_dist_d = '0;
            end
          endcase
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A mode write clears the governor state
    if (mode_wr) begin
      rate_valid_d = 1'b0;
      smoothed_d   = FPS_START;
      total_d      = '0;
      dist_d       = '0;
      dist_set_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rate_valid_q <= 1'b0;
      smoothed_q   <= FPS_START;
      total_q      <= '0;
      dist_q       <= '0;
      dist_set_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      rate_valid_q <= rate_valid_d;
      smoothed_q   <= smoothed_d;
      total_q      <= total_d;
      dist_q       <= dist_d;
      dist_set_q   <= dist_set_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    elapsed_q  <= elapsed_d;
    fps_q      <= fps_d;
    cur_q      <= cur_d;
    diff_q     <= diff_d;
    below_q    <= below_d;
    changed_q  <= changed_d;
    out_en_q   <= out_en_d;
    out_dist_q <= out_dist_d;
    out_chg_q  <= out_chg_d;
  end

  // Register file; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= afcg_pkg::MODE_OFF;
      fixed_dist_q <= '0;
      min_fps_q    <= MIN_FPS_RST;
      max_fps_q    <= MAX_FPS_RST;
      min_dist_q   <= MIN_DIST_RST;
      init_dist_q  <= INIT_DIST_RST;
      max_dist_q   <= MAX_DIST_RST;
    end else if (cfg_fire) begin
      case (cfg_i.index)
        afcg_pkg::REG_CLIP_MODE:  mode_q       <= cfg_i.data[MODE_W-1:0];
        afcg_pkg::REG_FIXED_DIST: fixed_dist_q <= cfg_i.data[DIST_W-1:0];
        afcg_pkg::REG_MIN_FPS:    min_fps_q    <= cfg_i.data[FPS_W-1:0];
        afcg_pkg::REG_MAX_FPS:    max_fps_q    <= cfg_i.data[FPS_W-1:0];
        afcg_pkg::REG_MIN_DIST:   min_dist_q   <= cfg_i.data[DIST_W-1:0];
        afcg_pkg::REG_INIT_DIST:  init_dist_q  <= cfg_i.data[DIST_W-1:0];
        afcg_pkg::REG_MAX_DIST:   max_dist_q   <= cfg_i.data[DIST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.plane_enabled    = out_en_q;
  assign out_o.clip_distance    = out_dist_q;
  assign out_o.distance_changed = out_chg_q;

`ifndef ASSERT_OFF
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != S_IDLE))
    else $error("accepted item did not start work");

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide step");

  a_div_needs_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rate_valid_q && (mode_q == afcg_pkg::MODE_ADAPT)))
    else $error("divide without an armed adaptive rate");

  a_total_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (total_q <= PERIOD))
    else $error("accumulated time above the adjust period while idle");

  a_changed_has_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_chg_q) |-> (dist_set_q && out_en_q))
    else $error("distance change reported without a set distance");
`endif

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for adaptive_far_clip_governor_top: frame stimulus, register
// phases and an in-bench predictor of the clip distance. Needs afcg_pkg, afcg_if.
module tb_top;
  import afcg_pkg::*;

  localparam int unsigned FRAC_BITS        = 8;
  localparam int unsigned ADJUST_PERIOD_MS = 500;

  // One second as 1000 ms in fixed point, and the 30 fps starting estimate
  localparam logic [31:0]      FPS_ONE_SECOND = 32'(1000) << FRAC_BITS;
  localparam logic [FPS_W-1:0] FPS_START      = FPS_W'(30 << FRAC_BITS);

  // Codes outside the documented set: mode three behaves as off, index seven is ignored
  localparam logic [MODE_W-1:0]    MODE_RESERVED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 3'd7;

  localparam int unsigned RAND_PHASES     = 12;
  localparam int unsigned FRAMES_PER_PHASE = 102;
  localparam int unsigned HOLD_PHASE      = 5;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned TAIL_CYCLES     = 40;
  localparam int unsigned TIMEOUT_NS      = 4_000_000;

  typedef struct packed {
    logic              plane_enabled;
    logic [DIST_W-1:0] clip_distance;
    logic              distance_changed;
  } clip_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  afcg_in_if  in_if ();
  afcg_out_if out_if ();
  afcg_cfg_if cfg_if ();

  adaptive_far_clip_governor_top #(
    .FRAC_BITS       (FRAC_BITS),
    .ADJUST_PERIOD_MS(ADJUST_PERIOD_MS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: register copy and governor state, updated on handshakes only
  // ---------------------------------------------------------------------------
  logic [MODE_W-1:0]  gov_mode       = MODE_OFF;
  logic [DIST_W-1:0]  gov_fixed_dist = '0;
  logic [FPS_W-1:0]   gov_min_fps    = FPS_W'(20 << FRAC_BITS);
  logic [FPS_W-1:0]   gov_max_fps    = FPS_W'(40 << FRAC_BITS);
  logic [DIST_W-1:0]  gov_min_dist   = DIST_W'(1 << FRAC_BITS);
  logic [DIST_W-1:0]  gov_init_dist  = DIST_W'(200 << FRAC_BITS);
  logic [DIST_W-1:0]  gov_max_dist   = DIST_W'(1000 << FRAC_BITS);

  logic               rate_seen      = 1'b0;
  logic [FPS_W-1:0]   fps_avg        = FPS_START;
  logic [TOTAL_W-1:0] ms_accum       = '0;
  logic [DIST_W-1:0]  far_dist       = '0;
  logic               far_dist_held  = 1'b0;

  // Mirror one register write; a mode write also restarts the rate estimate.
  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0]  idx,
                                          input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_CLIP_MODE: begin
        gov_mode      = data[MODE_W-1:0];
        rate_seen     = 1'b0;
        fps_avg       = FPS_START;
        ms_accum      = '0;
        far_dist      = '0;
        far_dist_held = 1'b0;
      end
      REG_FIXED_DIST: gov_fixed_dist = data[DIST_W-1:0];
      REG_MIN_FPS:    gov_min_fps    = data[FPS_W-1:0];
      REG_MAX_FPS:    gov_max_fps    = data[FPS_W-1:0];
      REG_MIN_DIST:   gov_min_dist   = data[DIST_W-1:0];
      REG_INIT_DIST:  gov_init_dist  = data[DIST_W-1:0];
      REG_MAX_DIST:   gov_max_dist   = data[DIST_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the adaptive state by one frame; return 1 when a distance was written.
  function automatic logic adapt_distance(input logic [ELAPSED_W-1:0] elapsed);
    logic [31:0] fps;
    logic [63:0] dist_next;
    logic [63:0] delta;
    if (!rate_seen) begin
      rate_seen = 1'b1;
      return 1'b0;
    end
    fps = (elapsed == '0) ? FPS_ONE_SECOND : FPS_ONE_SECOND / 32'(elapsed);
    if (fps > 32'(FPS_MAX)) fps = 32'(FPS_MAX);
    fps_avg  = FPS_W'((fps + 32'(fps_avg)) >> 1);
    ms_accum = ms_accum + TOTAL_W'(elapsed);
    if (32'(ms_accum) <= ADJUST_PERIOD_MS) return 1'b0;
    ms_accum  = '0;
    dist_next = 64'(far_dist_held ? far_dist : gov_init_dist);
    if (fps_avg < gov_min_fps) begin
      // Too slow: pull the plane in, never below the floor (nor below zero)
      delta = 64'(gov_min_fps - fps_avg);
      if (dist_next < delta + 64'(gov_min_dist)) dist_next = 64'(gov_min_dist);
      else dist_next = dist_next - delta;
    end else if (fps_avg > gov_max_fps) begin
      // Too fast: push the plane out, saturate at the ceiling
      delta     = 64'(fps_avg - gov_max_fps);
      dist_next = dist_next + delta;
      if (dist_next > 64'(gov_max_dist)) dist_next = 64'(gov_max_dist);
    end else begin
      return 1'b0;
    end
    far_dist      = dist_next[DIST_W-1:0];
    far_dist_held = 1'b1;
    return 1'b1;
  endfunction

  // Expected result for one accepted frame under the current mode.
  function automatic clip_result_t frame_outcome(input logic [ELAPSED_W-1:0] elapsed);
    clip_result_t r;
    r = '0;
    case (gov_mode)
      MODE_FIXED: begin
        r.plane_enabled = 1'b1;
        r.clip_distance = gov_fixed_dist;
      end
      MODE_ADAPT: begin
        r.distance_changed = adapt_distance(elapsed);
        r.plane_enabled    = 1'b1;
        r.clip_distance    = far_dist_held ? far_dist : '0;
      end
      default: ;  // off and the reserved mode leave the state alone
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus queues, counters and idling knobs
  // ---------------------------------------------------------------------------
  logic [ELAPSED_W-1:0] frame_q[$];
  clip_result_t         outcome_q[$];
  int unsigned          frames_sent_cnt = 0;
  int unsigned          results_cnt     = 0;
  int unsigned          fail_cnt        = 0;
  int unsigned          send_idle_pct   = 0;
  int unsigned          recv_stall_pct  = 0;
  logic                 hold_request    = 1'b0;
  logic                 rx_hold         = 1'b0;

  // Frame driver: advance to the next queued frame once the current one is taken,
  // or drop valid for a random idle cycle.
  always @(posedge clk_i) begin
    if (rst_ni && (!in_if.valid || in_if.ready)) begin
      if (frame_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_if.valid      <= 1'b1;
        in_if.elapsed_ms <= frame_q.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result sink: stall at random, and hold off entirely during the long hold.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering frames and
  // the block backs up into its input.
  initial begin : receiver_hold_off
    wait (hold_request);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Checker: compare each returned item with the oldest prediction, mirror
  // register writes, and predict every accepted frame. All values are sampled
  // at the edge, before any nonblocking update of this step lands.
  always @(posedge clk_i) begin : frame_check
    clip_result_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        results_cnt++;
        if (outcome_q.size() == 0) begin
          $error("result with no frame pending: plane_enabled=%0d clip_distance=%0d",
                 out_if.plane_enabled, out_if.clip_distance);
          fail_cnt++;
        end else begin
          want = outcome_q.pop_front();
          if (out_if.plane_enabled !== want.plane_enabled) begin
            $error("plane_enabled: expected %0d, got %0d",
                   want.plane_enabled, out_if.plane_enabled);
            fail_cnt++;
          end
          if (out_if.clip_distance !== want.clip_distance) begin
            $error("clip_distance: expected %0d, got %0d",
                   want.clip_distance, out_if.clip_distance);
            fail_cnt++;
          end
          if (out_if.distance_changed !== want.distance_changed) begin
            $error("distance_changed: expected %0d, got %0d",
                   want.distance_changed, out_if.distance_changed);
            fail_cnt++;
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) apply_reg_write(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready) outcome_q.push_back(frame_outcome(in_if.elapsed_ms));
    end
  end

  task automatic queue_frame(input logic [ELAPSED_W-1:0] elapsed);
    frame_q.push_back(elapsed);
    frames_sent_cnt++;
  endtask

  // Hold the sender until every queued frame has come back, then let the block settle.
  task automatic drain_frames();
    while (results_cnt != frames_sent_cnt) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0]  idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed frames, random phases, wrap-up
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned        ph;
    int unsigned        n;
    int unsigned        burst;
    int unsigned        regime;
    int unsigned        pick;
    logic [FPS_W-1:0]   fps_lo;
    logic [FPS_W-1:0]   fps_hi;
    logic [DIST_W-1:0]  d_min;
    logic [DIST_W-1:0]  d_max;
    logic [DIST_W-1:0]  d_init;
    logic [MODE_W-1:0]  mode_sel;

    in_if.valid      = 1'b0;
    in_if.elapsed_ms = '0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Off mode straight out of reset: plane disabled whatever the frame time
    queue_frame('0);
    queue_frame('1);
    queue_frame(16'd1);
    drain_frames();

    // Fixed mode, first with a zero distance, then the largest one; junk in the
    // upper data bits of the mode write and a write to an unmapped index
    write_register(REG_UNUSED, CFG_DATA_W'($urandom));
    write_register(REG_FIXED_DIST, '0);
    write_register(REG_CLIP_MODE, {22'($urandom), MODE_FIXED});
    queue_frame('0);
    queue_frame('1);
    drain_frames();
    write_register(REG_FIXED_DIST, '1);
    queue_frame(16'd12);
    drain_frames();

    // Adaptive with reset bounds: first frame only arms the estimate, a zero
    // frame counts as 1000 fps, then fast and slow periods move the distance
    write_register(REG_CLIP_MODE, {22'($urandom), MODE_ADAPT});
    queue_frame(16'd40);
    queue_frame('0);
    queue_frame(16'd1);
    queue_frame(16'd600);
    queue_frame(16'd700);
    queue_frame(16'd700);
    queue_frame(16'd700);
    queue_frame('1);
    queue_frame('1);
    drain_frames();

    // Rate always short with a zero floor: the drop goes below zero and clamps
    write_register(REG_MIN_FPS, {4'($urandom), {FPS_W{1'b1}}});
    write_register(REG_MAX_FPS, {4'($urandom), {FPS_W{1'b1}}});
    write_register(REG_MIN_DIST, '0);
    write_register(REG_INIT_DIST, '0);
    write_register(REG_MAX_DIST, '0);
    write_register(REG_CLIP_MODE, CFG_DATA_W'(MODE_ADAPT));
    queue_frame(16'd5);
    queue_frame(16'd600);
    queue_frame(16'd600);
    drain_frames();

    // Rate always in excess from the top distance: saturate at the ceiling
    write_register(REG_MIN_FPS, '0);
    write_register(REG_MAX_FPS, '0);
    write_register(REG_INIT_DIST, '1);
    write_register(REG_MAX_DIST, '1);
    write_register(REG_CLIP_MODE, CFG_DATA_W'(MODE_ADAPT));
    queue_frame(16'd1);
    queue_frame(16'd501);
    queue_frame(16'd501);
    drain_frames();

    // Reserved mode acts as off
    write_register(REG_CLIP_MODE, CFG_DATA_W'(MODE_RESERVED));
    queue_frame(16'd10);
    queue_frame('0);
    drain_frames();

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      // Rotate the idling pattern so gaps land on every step of the frame work
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      if (ph == HOLD_PHASE) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end

      // Mostly realistic rate windows and distance ranges, sometimes anything
      if ($urandom_range(7) == 0) begin
        fps_lo = FPS_W'($urandom);
        fps_hi = FPS_W'($urandom);
      end else begin
        fps_lo = FPS_W'($urandom_range(60 << FRAC_BITS, 5 << FRAC_BITS));
        fps_hi = fps_lo + FPS_W'($urandom_range(60 << FRAC_BITS));
      end
      if ($urandom_range(7) == 0) begin
        d_min  = DIST_W'($urandom);
        d_max  = DIST_W'($urandom);
        d_init = DIST_W'($urandom);
      end else begin
        d_min  = DIST_W'($urandom_range(50 << FRAC_BITS));
        d_max  = d_min + DIST_W'($urandom_range(2000 << FRAC_BITS));
        d_init = DIST_W'($urandom_range(2200 << FRAC_BITS));
      end
      pick = $urandom_range(19);
      if (pick < 14)      mode_sel = MODE_ADAPT;
      else if (pick < 17) mode_sel = MODE_FIXED;
      else if (pick < 19) mode_sel = MODE_OFF;
      else                mode_sel = MODE_RESERVED;

      write_register(REG_FIXED_DIST, DIST_W'($urandom));
      write_register(REG_MIN_FPS, {4'($urandom), fps_lo});
      write_register(REG_MAX_FPS, {4'($urandom), fps_hi});
      write_register(REG_MIN_DIST, d_min);
      write_register(REG_INIT_DIST, d_init);
      write_register(REG_MAX_DIST, d_max);
      if ($urandom_range(3) == 0) write_register(REG_UNUSED, CFG_DATA_W'($urandom));
      write_register(REG_CLIP_MODE, {22'($urandom), mode_sel});

      if (ph == HOLD_PHASE) hold_request = 1'b1;

      // Frames come in bursts of one regime so the smoothed rate actually
      // crosses the window and the period accumulates past its limit
      n = 0;
      while (n < FRAMES_PER_PHASE) begin
        burst  = $urandom_range(30, 6);
        regime = $urandom_range(9);
        repeat (burst) begin
          if (n < FRAMES_PER_PHASE) begin
            case (regime)
              0, 1, 2, 3: queue_frame(ELAPSED_W'($urandom_range(40, 1)));
              4, 5, 6, 7: queue_frame(ELAPSED_W'($urandom_range(900, 60)));
              8: queue_frame(($urandom_range(3) == 0) ? '0 : ELAPSED_W'($urandom));
              default: queue_frame(ELAPSED_W'($urandom_range(1)));
            endcase
            n++;
          end
        end
      end
      drain_frames();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (outcome_q.size() != 0) begin
      $error("%0d predicted results never returned", outcome_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("[adaptive_far_clip_governor_top] OK");
    end else begin
      $display("[adaptive_far_clip_governor_top] ERROR");
    end
    $finish;
  end

  // Hard stop if the block hangs on a handshake
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("[adaptive_far_clip_governor_top] ERROR");
    $finish;
  end

endmodule
